@@ rtl/escaped_tag_stripper_top_macros.svh @@
// Assertion macros used by the lookahead window of the escaped tag stripper RTL.
`ifndef ESCAPED_TAG_STRIPPER_TOP_MACROS_SVH
`define ESCAPED_TAG_STRIPPER_TOP_MACROS_SVH

// Plain invariant, checked on every rising clock edge outside reset.
`define ETS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ETS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);

// Next-cycle implication.
`define ETS_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/ets_pkg.sv @@
// Shared constants and types of the escaped tag stripper.
package ets_pkg;

  localparam int unsigned LOOKAHEAD = 6;
  localparam int unsigned BUF_BYTES = 1024;
  localparam int unsigned WIN_DEPTH = 8;
  localparam int unsigned LEN_W     = 10;

  typedef logic [LEN_W-1:0] len_t;

  localparam int unsigned LEN_MAX   = (1 << LEN_W) - 1;
  localparam int unsigned CAP_CLAMP = (BUF_BYTES - 1 > LEN_MAX) ? LEN_MAX : BUF_BYTES - 1;
  localparam len_t        CAP_LEN   = len_t'(CAP_CLAMP);
  localparam len_t        MAX_LENGTH_RST = len_t'(LEN_MAX);

  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_AMP    = 8'd38;
  localparam logic [7:0] CH_LBRK   = 8'd91;
  localparam logic [7:0] CH_RBRK   = 8'd93;
  localparam logic [7:0] CH_B      = 8'd98;
  localparam logic [7:0] CH_G      = 8'd103;
  localparam logic [7:0] CH_L      = 8'd108;
  localparam logic [7:0] CH_R      = 8'd114;
  localparam logic [7:0] CH_T      = 8'd116;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_BAR    = 8'd124;

  // One held input byte; fs marks the first byte of a field.
  typedef struct packed {
    logic       fs;
    logic [7:0] data;
  } win_entry_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } res_t;

endpackage

@@ rtl/ets_stream_if.sv @@
// Valid/ready stream interfaces for the input bytes and the cleaned bytes.
interface ets_in_if;
  logic       valid;
  logic       ready;
  logic       field_start;
  logic [7:0] data_byte;

  modport source (output valid, output field_start, output data_byte, input ready);
  modport sink   (input valid, input field_start, input data_byte, output ready);
endinterface

interface ets_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

@@ rtl/escaped_tag_stripper_top.sv @@
// A byte that decides alone passes the window register, then the result register; an '&'
// that may open "&lt" or "&gt" is held until up to 5 following bytes (or the next field) land.
// Throughput: one byte per cycle while the result register is free and the head need not wait,
// set by the single decision on the window head; a tag closer before a non-space byte adds another.
// Reset (async, active low): window empty, field state cleared as at a field start,
// max_length back to 1023, no result beat pending.
module escaped_tag_stripper_top #(
  parameter int unsigned WIN_DEPTH = ets_pkg::WIN_DEPTH  // held bytes, at least LOOKAHEAD
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  ets_pkg::len_t        cfg_wdata_i,
  ets_in_if.sink               in_i,
  ets_out_if.source            out_o
);

  localparam int unsigned CntW = $clog2(WIN_DEPTH + 1);

  ets_pkg::len_t       max_length_q;
  ets_pkg::win_entry_t push_data;
  ets_pkg::win_entry_t win_ent [WIN_DEPTH];
  logic [CntW-1:0]     win_cnt;
  logic                win_full, push;
  logic [1:0]          pop;
  logic                res_valid, can_ld, out_valid;
  ets_pkg::res_t       res, out_res;

  // Single config register; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= ets_pkg::MAX_LENGTH_RST;
    end else if (cfg_we_i) begin
      max_length_q <= cfg_wdata_i;
    end
  end

  // Input beats go straight into the window; ready only depends on its fill,
  // so a waiting result never blocks intake until the window itself is full.
  assign in_i.ready        = !win_full;
  assign push              = in_i.valid && !win_full;
  assign push_data.fs      = in_i.field_start;
  assign push_data.data    = in_i.data_byte;

  ets_window #(
    .WIN_DEPTH (WIN_DEPTH)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .full_o      (win_full),
    .ent_o       (win_ent),
    .count_o     (win_cnt)
  );

  // Decision on the window head: consumes 0, 1 or 3 bytes and makes at most
  // one result beat. Bytes after a field start count as absent for the head,
  // which flushes the previous field without waiting.
  ets_engine #(
    .WIN_DEPTH (WIN_DEPTH)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_length_i (max_length_q),
    .ent_i        (win_ent),
    .count_i      (win_cnt),
    .fire_i       (can_ld),
    .pop_o        (pop),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // Result register; the engine only advances when it can take a beat.
  ets_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (res_valid),
    .ld_res_i    (res),
    .can_ld_o    (can_ld),
    .out_valid_o (out_valid),
    .out_res_o   (out_res),
    .out_ready_i (out_o.ready)
  );

  assign out_o.valid    = out_valid;
  assign out_o.out_byte = out_res.out_byte;
  assign out_o.last     = out_res.last;

endmodule

@@ rtl/ets_window.sv @@
// Lookahead window: shift buffer of held input bytes with pop of 0, 1 or 3.
`include "escaped_tag_stripper_top_macros.svh"

module ets_window #(
  parameter int unsigned WIN_DEPTH = ets_pkg::WIN_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  ets_pkg::win_entry_t            push_data_i,
  input  logic [1:0]                     pop_i,
  output logic                           full_o,
  output ets_pkg::win_entry_t            ent_o [WIN_DEPTH],
  output logic [$clog2(WIN_DEPTH+1)-1:0] count_o
);

  localparam int unsigned CntW = $clog2(WIN_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(WIN_DEPTH);

  ets_pkg::win_entry_t ent_q [WIN_DEPTH];
  ets_pkg::win_entry_t ent_d [WIN_DEPTH];
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [CntW-1:0]     cnt_rem;
  logic [IdxW-1:0]     wr_idx;

  always_comb begin
    for (int i = 0; i < WIN_DEPTH; i++) begin
      ent_d[i] = ent_q[i];
      case (pop_i)
        2'd1: begin
          if (i + 1 < WIN_DEPTH) ent_d[i] = ent_q[i+1];
        end
        2'd3: begin
          if (i + 3 < WIN_DEPTH) ent_d[i] = ent_q[i+3];
        end
        default: ent_d[i] = ent_q[i];
      endcase
    end
    cnt_rem = cnt_q - CntW'(pop_i);
    wr_idx  = cnt_rem[IdxW-1:0];
    if (push_i) ent_d[wr_idx] = push_data_i;
    cnt_d = cnt_rem + CntW'(push_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o   = ent_q;
  assign count_o = cnt_q;
  assign full_o  = (cnt_q == CntW'(WIN_DEPTH));

  `ETS_ASSERT(a_cnt_bound, cnt_q <= CntW'(WIN_DEPTH), "window count over depth")
  `ETS_ASSERT(a_pop_le_cnt, CntW'(pop_i) <= cnt_q, "pop larger than held bytes")
  `ETS_ASSERT_IMP(a_no_push_full, full_o, !push_i, "push into full window")
  `ETS_ASSERT_NXT(a_cnt_grow, push_i && (pop_i == 2'd0), cnt_q == $past(cnt_q) + 1'b1, "count lost a push")

endmodule

@@ rtl/ets_engine.sv @@
// Field state and one decision per cycle on the head of the window while the result register can take a beat.
module ets_engine #(
  parameter int unsigned WIN_DEPTH = ets_pkg::WIN_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ets_pkg::len_t                  max_length_i,
  input  ets_pkg::win_entry_t            ent_i [WIN_DEPTH],
  input  logic [$clog2(WIN_DEPTH+1)-1:0] count_i,
  input  logic                           fire_i,
  output logic [1:0]                     pop_o,
  output logic                           res_valid_o,
  output ets_pkg::res_t                  res_o
);

  localparam int unsigned CntW = $clog2(WIN_DEPTH + 1);
  localparam int unsigned LaTop = ets_pkg::LOOKAHEAD - 1;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_TAG    = 3'b010,
    MODE_DONE   = 3'b100
  } mode_e;

  typedef struct packed {
    mode_e         mode;
    logic [1:0]    drop;
    ets_pkg::len_t out_cnt;
    logic          at_start;
  } fld_t;

  localparam fld_t FldClear = '{mode: MODE_NORMAL, drop: 2'd0, out_cnt: '0, at_start: 1'b1};

  fld_t          st_q, st_d, eff, st_n;
  ets_pkg::len_t cap, cnt_inc;
  logic          has, stall, act, req, rend, emit_ok, fin, is_br, lt_head;
  logic [7:0]    b, rch;
  logic [1:0]    pop;
  logic [LaTop:1] vld, fsv, pres, wt;
  logic [LaTop:0] pre_fs;

  // Peek status: present, absent (later field already here) or wait.
  always_comb begin
    pre_fs[0] = 1'b0;
    for (int k = 1; k <= LaTop; k++) begin
      vld[k]    = (CntW'(k) < count_i);
      fsv[k]    = vld[k] & ent_i[k].fs;
      pre_fs[k] = pre_fs[k-1] | fsv[k];
      pres[k]   = vld[k] & ~pre_fs[k];
    end
    fin = pre_fs[LaTop];
    for (int k = 1; k <= LaTop; k++) begin
      wt[k] = ~pres[k] & ~fin;
    end
  end

  always_comb begin
    cap = (max_length_i > ets_pkg::CAP_LEN) ? ets_pkg::CAP_LEN : max_length_i;
    has = (count_i != '0);
    b   = ent_i[0].data;
    eff = (has && ent_i[0].fs) ? FldClear : st_q;

    is_br = pres[LaTop-1] && (ent_i[LaTop-1].data == ets_pkg::CH_B) &&
            pres[LaTop] && (ent_i[LaTop].data == ets_pkg::CH_R);
    lt_head = (b == ets_pkg::CH_AMP) && pres[1] && (ent_i[1].data == ets_pkg::CH_L);

    st_n  = eff;
    pop   = 2'd0;
    req   = 1'b0;
    rch   = b;
    rend  = 1'b0;
    stall = 1'b0;

    unique case (eff.mode)
      MODE_DONE: begin
        pop = 2'd1;
      end
      MODE_TAG: begin
        if (eff.drop == 2'd2) begin
          st_n.drop = 2'd1;
          pop       = 2'd1;
        end else if (eff.drop == 2'd1) begin
          st_n.drop = 2'd0;
          st_n.mode = MODE_NORMAL;
          pop       = (b == ets_pkg::CH_SPACE) ? 2'd1 : 2'd0;
        end else if (b != ets_pkg::CH_AMP) begin
          pop = 2'd1;
        end else if (wt[1]) begin
          stall = 1'b1;
        end else if (!pres[1] || ent_i[1].data != ets_pkg::CH_G) begin
          pop = 2'd1;
        end else if (wt[2]) begin
          stall = 1'b1;
        end else if (!pres[2] || ent_i[2].data != ets_pkg::CH_T) begin
          pop = 2'd1;
        end else begin
          st_n.drop = 2'd2;
          pop       = 2'd3;
        end
      end
      MODE_NORMAL: begin
        if (eff.drop == 2'd2) begin
          st_n.drop = 2'd1;
          pop       = 2'd1;
        end else if (eff.drop == 2'd1) begin
          st_n.drop = 2'd0;
          req       = 1'b1;
          pop       = 2'd1;
        end else if ((b == ets_pkg::CH_AMP) && wt[1]) begin
          stall = 1'b1;
        end else if (lt_head && wt[2]) begin
          stall = 1'b1;
        end else if (lt_head && pres[2] && (ent_i[2].data == ets_pkg::CH_T)) begin
          if (wt[LaTop-1] || wt[LaTop]) begin
            stall = 1'b1;
          end else begin
            req       = !eff.at_start;
            st_n.mode = MODE_TAG;
            pop       = 2'd3;
          end
        end else if ((b == ets_pkg::CH_LBRK) || (b == ets_pkg::CH_LBRACE)) begin
          st_n.drop = 2'd2;
          pop       = 2'd1;
        end else begin
          req = 1'b1;
          pop = 2'd1;
        end
      end
      default: begin
        st_n.mode = MODE_NORMAL;
      end
    endcase

    // Character for the emitted beat
    if (st_n.mode == MODE_TAG && req) begin
      rch = is_br ? ets_pkg::CH_SPACE : ets_pkg::CH_BAR;
    end else if ((b == ets_pkg::CH_NL) || (b == ets_pkg::CH_RBRK)) begin
      rch  = ets_pkg::CH_QUOTE;
      rend = 1'b1;
    end

    // Length cap
    cnt_inc = eff.out_cnt + ets_pkg::len_t'(1);
    emit_ok = 1'b0;
    if (req) begin
      if (eff.out_cnt >= cap) begin
        st_n.mode = MODE_DONE;
      end else begin
        st_n.out_cnt  = cnt_inc;
        st_n.at_start = 1'b0;
        emit_ok       = 1'b1;
        if (cnt_inc >= cap) rend = 1'b1;
        if (rend) st_n.mode = MODE_DONE;
      end
    end

    act  = fire_i && has && !stall;
    st_d = act ? st_n : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= FldClear;
    end else begin
      st_q <= st_d;
    end
  end

  assign pop_o          = act ? pop : 2'd0;
  assign res_valid_o    = act && emit_ok;
  assign res_o.out_byte = rch;
  assign res_o.last     = rend;

endmodule

@@ rtl/ets_outreg.sv @@
// Result register between the decision logic and the output channel.
module ets_outreg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ld_i,
  input  ets_pkg::res_t ld_res_i,
  output logic          can_ld_o,
  output logic          out_valid_o,
  output ets_pkg::res_t out_res_o,
  input  logic          out_ready_i
);

  logic          vld_q, vld_d;
  ets_pkg::res_t res_q;

  assign can_ld_o = !vld_q || out_ready_i;
  assign vld_d    = can_ld_o ? ld_i : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i && can_ld_o) res_q <= ld_res_i;
  end

  assign out_valid_o = vld_q;
  assign out_res_o   = res_q;

endmodule

@@ tb/sv/ets_strip_sb_pkg.sv @@
// Scoreboard class for the escaped tag stripper: byte-level predictor and result checker.
`timescale 1ns / 1ps
package ets_strip_sb_pkg;

  typedef enum logic [1:0] {MD_COPY, MD_TAG, MD_DONE} strip_mode_e;

  class strip_scoreboard;
    logic [7:0]         win [ets_pkg::LOOKAHEAD];
    int                 fill;
    strip_mode_e        mode;
    int                 drops;
    int unsigned        sent;
    bit                 fresh;
    ets_pkg::len_t      cap_reg;
    ets_pkg::res_t      due [$];
    int unsigned        mismatches;
    int unsigned        beats;

    function new();
      wipe_field();
      cap_reg    = ets_pkg::MAX_LENGTH_RST;
      mismatches = 0;
      beats      = 0;
    endfunction

    function void set_cap(ets_pkg::len_t v);
      cap_reg = v;
    endfunction

    function void wipe_field();
      foreach (win[i]) win[i] = '0;
      fill  = 0;
      mode  = MD_COPY;
      drops = 0;
      sent  = 0;
      fresh = 1'b1;
    endfunction

    // One output char; the cap can end the field here, silently if already reached.
    function void put_char(logic [7:0] ch, bit fin_mark);
      int unsigned   lim;
      ets_pkg::res_t r;
      lim = cap_reg;
      if (lim > ets_pkg::CAP_CLAMP) lim = ets_pkg::CAP_CLAMP;
      if (mode == MD_DONE) return;
      if (sent >= lim) begin
        mode = MD_DONE;
        fill = 0;
        return;
      end
      sent++;
      fresh = 1'b0;
      if (sent >= lim) fin_mark = 1'b1;
      r.out_byte = ch;
      r.last     = fin_mark;
      due.push_back(r);
      if (fin_mark) begin
        mode = MD_DONE;
        fill = 0;
      end
    endfunction

    function void copy_plain(logic [7:0] b);
      if (b == ets_pkg::CH_NL || b == ets_pkg::CH_RBRK) put_char(ets_pkg::CH_QUOTE, 1'b1);
      else put_char(b, 1'b0);
    endfunction

    // 1: byte held, 0: missing at flush, -1: not yet known
    function int look(int k, bit fin, output logic [7:0] v);
      v = '0;
      if (k < fill) begin
        v = win[k];
        return 1;
      end
      return fin ? 0 : -1;
    endfunction

    // Decide the window head; returns bytes consumed or -1 to wait.
    function int decide_head(bit fin);
      logic [7:0] b, v, v4, v5;
      int         r, r4, r5;
      bit         br;
      b = win[0];
      if (mode == MD_TAG) begin
        if (drops == 2) begin
          drops = 1;
          return 1;
        end
        if (drops == 1) begin
          drops = 0;
          mode  = MD_COPY;
          return (b == ets_pkg::CH_SPACE) ? 1 : 0;
        end
        if (b != ets_pkg::CH_AMP) return 1;
        r = look(1, fin, v);
        if (r < 0) return -1;
        if (r == 0 || v != ets_pkg::CH_G) return 1;
        r = look(2, fin, v);
        if (r < 0) return -1;
        if (r == 0 || v != ets_pkg::CH_T) return 1;
        drops = 2;
        return 3;
      end
      if (drops == 2) begin
        drops = 1;
        return 1;
      end
      if (drops == 1) begin
        drops = 0;
        copy_plain(b);
        return 1;
      end
      if (b == ets_pkg::CH_AMP) begin
        r = look(1, fin, v);
        if (r < 0) return -1;
        if (r == 1 && v == ets_pkg::CH_L) begin
          r = look(2, fin, v);
          if (r < 0) return -1;
          if (r == 1 && v == ets_pkg::CH_T) begin
            r4 = look(4, fin, v4);
            r5 = look(5, fin, v5);
            if (r4 < 0 || r5 < 0) return -1;
            if (!fresh) begin
              br = (r4 == 1 && v4 == ets_pkg::CH_B && r5 == 1 && v5 == ets_pkg::CH_R);
              put_char(br ? ets_pkg::CH_SPACE : ets_pkg::CH_BAR, 1'b0);
            end
            if (mode != MD_DONE) mode = MD_TAG;
            return 3;
          end
        end
      end
      if (b == ets_pkg::CH_LBRK || b == ets_pkg::CH_LBRACE) begin
        drops = 2;
        return 1;
      end
      copy_plain(b);
      return 1;
    endfunction

    function void settle(bit fin);
      int r, c, i;
      while (fill > 0 && mode != MD_DONE) begin
        r = decide_head(fin);
        if (mode == MD_DONE) begin
          fill = 0;
          break;
        end
        if (r < 0) break;
        if (r > 0) begin
          c = (r > fill) ? fill : r;
          for (i = 0; i + c < fill; i++) win[i] = win[i + c];
          fill -= c;
        end
      end
    endfunction

    // Accepted input byte; returns 1 unless the byte is ignored after a field end.
    function bit note_byte(bit fs, logic [7:0] b);
      if (fs) begin
        if (mode != MD_DONE) settle(1'b1);
        wipe_field();
      end
      if (mode == MD_DONE) return 1'b0;
      if (fill < ets_pkg::LOOKAHEAD) begin
        win[fill] = b;
        fill++;
      end
      settle(1'b0);
      return 1'b1;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Accepted result beat against the oldest expected char.
    function void check_char(logic [7:0] ch, logic last);
      ets_pkg::res_t want;
      beats++;
      if (due.size() == 0) begin
        flag($sformatf("extra beat: got byte %02h last %0b", ch, last));
        return;
      end
      want = due.pop_front();
      if (want.out_byte !== ch || want.last !== last)
        flag($sformatf("beat %0d: expected byte %02h last %0b, got byte %02h last %0b",
                       beats, want.out_byte, want.last, ch, last));
    endfunction
  endclass

endpackage

@@ tb/sv/escaped_tag_stripper_top_test.sv @@
// Top-level testbench for the escaped tag stripper: drives bytes, predicts and checks beats.
`timescale 1ns / 1ps
module escaped_tag_stripper_top_test;

  localparam int STALL_LIMIT = 1000;  // cycles without any beat before giving up
  localparam int TAIL_CYCLES = 12;    // covers the window and result register path plus a held '&'
  localparam int PHASE_BYTES = 28;    // input bytes per random phase, 6 phases

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we;
  ets_pkg::len_t cfg_wdata;

  ets_in_if  in_bus ();
  ets_out_if out_bus ();

  escaped_tag_stripper_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  ets_strip_sb_pkg::strip_scoreboard sb = new();

  logic [7:0]  plan [$];      // bytes of the field being built
  bit          calm_in;       // no gaps on the input side for this field
  bit          calm_out;      // no stalls on the output side for a while
  int unsigned fed;           // input bytes accepted by the block
  int          stuck;
  int unsigned settings;

  // Clock, 10 ns period.
  always #5 clk_i = ~clk_i;

  // Watchdog: any beat on either side resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stuck <= 0;
    end else if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
      if (stuck + 1 >= STALL_LIMIT) begin
        $display("escaped_tag_stripper_top_test: FAIL");
        $finish;
      end
    end
  end

  // Result side: random stall before each beat, with calm stretches of back-to-back
  // acceptance. Values are read right at the edge, so they are the pre-edge ones.
  initial begin : result_sink
    int stall;
    out_bus.ready = 1'b0;
    calm_out      = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) calm_out = !calm_out;
      stall = calm_out ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk_i);
      while (!(out_bus.valid && out_bus.ready)) @(posedge clk_i);
      sb.check_char(out_bus.out_byte, out_bus.last);
    end
  end

  // One input beat. valid stays high into the next call when that call has no gap,
  // so it is never dropped and raised within one step.
  task automatic send_byte(bit fs, logic [7:0] b);
    int gap;
    gap = calm_in ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.field_start <= fs;
    in_bus.data_byte   <= b;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    void'(sb.note_byte(fs, b));
    fed++;
  endtask

  task automatic send_field(string s, bit with_start);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(with_start && i == 0, s[i]);
  endtask

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) plan.push_back(s[i]);
  endfunction

  function automatic logic [7:0] letter();
    return 8'($urandom_range(97, 122));
  endfunction

  // Random field: mostly well-formed text with tags, brackets and an end marker;
  // about one in ten is raw noise with random field starts.
  task automatic rand_field();
    int parts, n, i;
    plan.delete();
    calm_in = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 8);
      repeat (n) send_byte($urandom_range(0, 3) == 0, 8'($urandom));
      return;
    end
    parts = $urandom_range(1, 7);
    repeat (parts) begin
      case ($urandom_range(0, 9)) inside
        [0:2]:   repeat ($urandom_range(1, 4)) plan.push_back(letter());
        3:       plan.push_back(8'($urandom));
        [4:5]: begin
          // escaped tag; sometimes no ';' which shifts the br lookup
          add_text(($urandom_range(0, 3) == 0) ? "&lt" : "&lt;");
          if ($urandom_range(0, 1) == 0) add_text("br");
          else repeat ($urandom_range(1, 3)) plan.push_back(letter());
          // a field end inside a tag must be swallowed
          if ($urandom_range(0, 5) == 0)
            plan.push_back($urandom_range(0, 1) ? ets_pkg::CH_NL : ets_pkg::CH_RBRK);
          if ($urandom_range(0, 7) != 0) add_text("&gt;");
          if ($urandom_range(0, 1) == 0) plan.push_back(ets_pkg::CH_SPACE);
        end
        6: begin
          // near misses of the tag markers
          case ($urandom_range(0, 3))
            0: add_text("&l");
            1: add_text("&g");
            2: add_text("&gt");
            default: add_text("&lx");
          endcase
        end
        7: begin
          // bracket drops itself and one byte; the next is copied, an end marker as a closing quote
          plan.push_back($urandom_range(0, 1) ? ets_pkg::CH_LBRK : ets_pkg::CH_LBRACE);
          plan.push_back(8'($urandom));
          plan.push_back($urandom_range(0, 2) == 0 ? ets_pkg::CH_RBRK : letter());
        end
        8:       plan.push_back(ets_pkg::CH_SPACE);
        default: plan.push_back($urandom_range(0, 1) ? ets_pkg::CH_NL : ets_pkg::CH_RBRK);
      endcase
    end
    if ($urandom_range(0, 9) < 7)
      plan.push_back($urandom_range(0, 1) ? ets_pkg::CH_NL : ets_pkg::CH_RBRK);
    for (i = 0; i < plan.size(); i++) send_byte(i == 0, plan[i]);
  endtask

  // Close out a phase: a fresh one-letter field flushes anything held in the window,
  // then wait for every expected beat plus the pipeline tail so the block is idle.
  task automatic finish_phase();
    send_byte(1'b1, "a");
    in_bus.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cap(ets_pkg::len_t v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_cap(v);
    settings++;
  endtask

  // Every input known from time zero; reset held low from the start.
  initial begin : main
    ets_pkg::len_t caps [6];
    int unsigned   start;
    int            p;
    int            leftover;

    rst_ni             = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.field_start = 1'b0;
    in_bus.data_byte   = '0;
    calm_in            = 1'b0;
    fed                = 0;
    settings           = 0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset cap, written once explicitly.
    write_cap(ets_pkg::MAX_LENGTH_RST);
    calm_in = 1'b0;
    // byte extremes, brace drop, ']' ends the field, trailing newline ignored
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_field("{z]\n", 1'b0);
    // br tag after text gives a space; closer and its space dropped
    send_field("q&lt;br&gt; r", 1'b1);
    // open tag cut by a new field: flushed as a bar, no last mark
    send_field("k&lt", 1'b1);
    // bracket swallows a newline, then ']' closes with a quote
    send_field("[\n]", 1'b1);
    finish_phase();

    // Random phases across cap settings: silent cap, the smallest caps, a short one,
    // the largest and one anywhere in range.
    caps[0] = '0;
    caps[1] = ets_pkg::len_t'(1);
    caps[2] = ets_pkg::len_t'(2);
    caps[3] = ets_pkg::len_t'($urandom_range(3, 40));
    caps[4] = ets_pkg::MAX_LENGTH_RST;
    caps[5] = ets_pkg::len_t'($urandom_range(1, 1022));
    for (p = 0; p < 6; p++) begin
      write_cap(caps[p]);
      start = fed;
      while (fed - start < PHASE_BYTES) rand_field();
      finish_phase();
    end

    leftover = sb.due.size();
    $display("run covered %0d input bytes and %0d result beats over %0d cap settings",
             fed, sb.beats, settings);
    $display("mismatches: %0d, expected beats never seen: %0d", sb.mismatches, leftover);
    if (sb.mismatches == 0 && leftover == 0) begin
      $display("escaped_tag_stripper_top_test: PASS");
    end else begin
      $display("escaped_tag_stripper_top_test: FAIL");
    end
    $finish;
  end

endmodule
